// ----- design/gde_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared constants, codes and controller/datapath types for the DFS engine.
package gde_pkg;

    localparam int VERT_W  = 6;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 64;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_E_RDB, S_E_CHK, S_E_WRB,
        S_R_U, S_R_CNT, S_R_RD, S_R_CMP, S_R_SH, S_R_MV, S_R_NEXT,
        S_S_TOP, S_S_LD, S_S_CNT, S_S_NEXT, S_S_W,
        S_EM_RD, S_EM_OUT,
        S_RESULT
    } gde_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_ADD, OP_ERR, OP_FULL,
        OP_E_RDA, OP_E_RDB, OP_E_WRA, OP_E_WRB,
        OP_R_START, OP_R_U, OP_R_CNT, OP_R_RD, OP_R_INC, OP_R_SHRD, OP_R_MV,
        OP_R_CNTWR, OP_R_NEXT,
        OP_S_START, OP_S_TOP, OP_S_LD, OP_S_CNT, OP_S_ADV, OP_S_POP, OP_S_PUSH,
        OP_EM_LOAD, OP_RES
    } gde_op_t;

    typedef struct packed {
        gde_op_t op;
        logic    in_ready;
    } gde_cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [FUNC_W-1:0] func;
        logic              a_bad;
        logic              edge_bad;
        logic              a_pres;
        logic              full;
        logic              i_ge_n;
        logic              match;
        logic              sh_end;
        logic              u_pres;
        logic              u_end;
        logic              sp_one;
        logic              w_seen;
        logic              em_last;
        logic              out_free;
    } gde_status_t;

endpackage

// ----- design/gde_if.sv -----
`timescale 1ns / 1ps
// Interfaces: operation word channel and result word channel.
interface gde_in_if;
    logic                      valid;
    logic                      ready;
    logic [gde_pkg::FUNC_W-1:0] func;
    logic [gde_pkg::VERT_W-1:0] vertex_a;
    logic [gde_pkg::VERT_W-1:0] vertex_b;
    modport source (output valid, func, vertex_a, vertex_b, input ready);
    modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

interface gde_out_if;
    logic                       valid;
    logic                       ready;
    logic [gde_pkg::VERT_W-1:0]  visited_vertex;
    logic                       last;
    logic [gde_pkg::STAT_W-1:0]  status;
    logic [gde_pkg::TOTAL_W-1:0] vertex_count;
    modport source (output valid, visited_vertex, last, status, vertex_count, input ready);
    modport sink   (input valid, visited_vertex, last, status, vertex_count, output ready);
endinterface

// ----- design/gde_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/gde_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: graph stores, walk stack, visit order buffer and result register.
module gde_datapath #(
    parameter int MAX_VERTICES = gde_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gde_pkg::MAX_DEGREE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gde_in_if.sink               in,
    gde_out_if.source            out,
    input  gde_pkg::gde_cmd_t    cmd,
    output gde_pkg::gde_status_t sts
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int SPW = $clog2(MAX_VERTICES + 1);
    localparam int LDEPTH = (1 << VW) * (1 << IW);
    localparam int XW = gde_pkg::VERT_W + 1;

    logic [gde_pkg::FUNC_W-1:0]  func_reg;
    logic [gde_pkg::VERT_W-1:0]  a_reg, b_reg;
    logic [VW-1:0]               u_reg;
    logic [CW-1:0]               i_reg, n_reg;
    logic [SPW-1:0]              sp_reg, k_reg;
    logic [VW-1:0]               e_reg;
    logic [gde_pkg::STAT_W-1:0]  st_reg;
    logic [MAX_VERTICES-1:0]     present_reg, visited_reg;
    logic [gde_pkg::TOTAL_W-1:0] total_reg;
    logic                        ov_reg;
    logic [gde_pkg::VERT_W-1:0]  ovx_reg;
    logic                        olast_reg;
    logic [gde_pkg::STAT_W-1:0]  ost_reg;
    logic [gde_pkg::TOTAL_W-1:0] ocnt_reg;

    logic [VW-1:0] a_v, b_v, stk_v, w;
    logic [CW-1:0] stk_i;

    // count store
    logic          cnt_we;
    logic [VW-1:0] cnt_wa, cnt_ra;
    logic [CW-1:0] cnt_wd, cnt_rd;
    // neighbor list store
    logic               lst_we;
    logic [VW+IW-1:0]   lst_wa, lst_ra;
    logic [VW-1:0]      lst_wd, lst_rd;
    // walk stack
    logic               stk_we;
    logic [VW-1:0]      stk_wa, stk_ra;
    logic [VW+CW-1:0]   stk_wd, stk_rd;
    // visit order
    logic               ord_we;
    logic [VW-1:0]      ord_wa;
    logic [VW-1:0]      ord_wd, ord_rd;

    logic [CW-1:0] i_inc, n_inc, n_dec;
    logic [CW:0]   i_inc_w;
    logic [SPW-1:0] sp_dec;
    logic          out_free;

    assign a_v    = a_reg[VW-1:0];
    assign b_v    = b_reg[VW-1:0];
    assign stk_v  = stk_rd[VW+CW-1:CW];
    assign stk_i  = stk_rd[CW-1:0];
    assign w      = lst_rd;
    assign i_inc_w = {1'b0, i_reg} + {{CW{1'b0}}, 1'b1};
    assign i_inc  = i_inc_w[CW-1:0];
    assign n_inc  = n_reg + {{(CW-1){1'b0}}, 1'b1};
    assign n_dec  = n_reg - {{(CW-1){1'b0}}, 1'b1};
    assign sp_dec = sp_reg - {{(SPW-1){1'b0}}, 1'b1};
    assign out_free = !ov_reg || out.ready;

    assign in.ready = cmd.in_ready;
    assign out.valid          = ov_reg;
    assign out.visited_vertex = ovx_reg;
    assign out.last           = olast_reg;
    assign out.status         = ost_reg;
    assign out.vertex_count   = ocnt_reg;

    always_comb
    begin
        sts.in_valid = in.valid;
        sts.func     = func_reg;
        sts.a_bad    = {1'b0, a_reg} >= XW'(MAX_VERTICES);
        sts.edge_bad = sts.a_bad || ({1'b0, b_reg} >= XW'(MAX_VERTICES)) || (a_reg == b_reg)
                       || !present_reg[a_v] || !present_reg[b_v];
        sts.a_pres   = present_reg[a_v];
        sts.full     = (n_reg >= CW'(MAX_DEGREE)) || (cnt_rd >= CW'(MAX_DEGREE));
        sts.i_ge_n   = i_reg >= n_reg;
        sts.match    = {{(gde_pkg::VERT_W-VW){1'b0}}, lst_rd} == a_reg;
        sts.sh_end   = i_inc_w >= {1'b0, n_reg};
        sts.u_pres   = present_reg[u_reg];
        sts.u_end    = u_reg == VW'(MAX_VERTICES - 1);
        sts.sp_one   = sp_reg == SPW'(1);
        sts.w_seen   = visited_reg[w];
        sts.em_last  = SPW'(e_reg) == (k_reg - SPW'(1));
        sts.out_free = out_free;
    end

    // store port control
    always_comb
    begin
        cnt_we = 1'b0;  cnt_wa = a_v;  cnt_wd = '0;  cnt_ra = a_v;
        lst_we = 1'b0;  lst_wa = {u_reg, i_reg[IW-1:0]};  lst_wd = lst_rd;
        lst_ra = {u_reg, i_reg[IW-1:0]};
        stk_we = 1'b0;  stk_wa = sp_dec[VW-1:0];  stk_wd = {u_reg, i_inc};
        stk_ra = sp_dec[VW-1:0];
        ord_we = 1'b0;  ord_wa = k_reg[VW-1:0];  ord_wd = w;
        case (cmd.op)
            gde_pkg::OP_ADD:
            begin
                cnt_we = !present_reg[a_v];
            end
            gde_pkg::OP_E_RDB:
            begin
                cnt_ra = b_v;
            end
            gde_pkg::OP_E_WRA:
            begin
                cnt_we = 1'b1;  cnt_wd = n_inc;
                lst_we = 1'b1;  lst_wa = {a_v, n_reg[IW-1:0]};  lst_wd = b_v;
            end
            gde_pkg::OP_E_WRB:
            begin
                cnt_we = 1'b1;  cnt_wa = b_v;  cnt_wd = i_inc;
                lst_we = 1'b1;  lst_wa = {b_v, i_reg[IW-1:0]};  lst_wd = a_v;
            end
            gde_pkg::OP_R_U:
            begin
                cnt_ra = u_reg;
            end
            gde_pkg::OP_R_SHRD:
            begin
                lst_ra = {u_reg, i_inc[IW-1:0]};
            end
            gde_pkg::OP_R_MV:
            begin
                lst_we = 1'b1;
            end
            gde_pkg::OP_R_CNTWR:
            begin
                cnt_we = 1'b1;  cnt_wa = u_reg;  cnt_wd = n_dec;
            end
            gde_pkg::OP_S_START:
            begin
                cnt_we = !present_reg[a_v];
                ord_we = 1'b1;  ord_wa = '0;  ord_wd = a_v;
                stk_we = 1'b1;  stk_wa = '0;  stk_wd = {a_v, {CW{1'b0}}};
            end
            gde_pkg::OP_S_LD:
            begin
                cnt_ra = stk_v;
            end
            gde_pkg::OP_S_ADV:
            begin
                stk_we = 1'b1;
            end
            gde_pkg::OP_S_PUSH:
            begin
                cnt_we = !present_reg[w];  cnt_wa = w;
                ord_we = 1'b1;
                stk_we = 1'b1;  stk_wa = sp_reg[VW-1:0];  stk_wd = {w, {CW{1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    gde_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd)
    );
    gde_ram #(.WIDTH(VW), .DEPTH(LDEPTH)) u_lst_ram (
        .clk(clk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd), .raddr(lst_ra), .rdata(lst_rd)
    );
    gde_ram #(.WIDTH(VW + CW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
    );
    gde_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(e_reg), .rdata(ord_rd)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            visited_reg <= '0;
            total_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.op == gde_pkg::OP_EM_LOAD || cmd.op == gde_pkg::OP_RES)
            begin
                ov_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (cmd.op)
                gde_pkg::OP_ADD:
                begin
                    if (!present_reg[a_v])
                    begin
                        present_reg[a_v] <= 1'b1;
                        total_reg        <= total_reg + 1'b1;
                    end
                end
                gde_pkg::OP_R_START:
                begin
                    present_reg[a_v] <= 1'b0;
                    total_reg        <= total_reg - 1'b1;
                end
                gde_pkg::OP_S_START:
                begin
                    // fresh marks: only the start vertex is visited
                    visited_reg <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_v;
                    if (!present_reg[a_v])
                    begin
                        present_reg[a_v] <= 1'b1;
                        total_reg        <= total_reg + 1'b1;
                    end
                end
                gde_pkg::OP_S_PUSH:
                begin
                    visited_reg[w] <= 1'b1;
                    if (!present_reg[w])
                    begin
                        present_reg[w] <= 1'b1;
                        total_reg      <= total_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result word
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gde_pkg::OP_LOAD:
            begin
                func_reg <= in.func;
                a_reg    <= in.vertex_a;
                b_reg    <= in.vertex_b;
                st_reg   <= gde_pkg::ST_OK;
            end
            gde_pkg::OP_ERR:    st_reg <= gde_pkg::ST_MISSING;
            gde_pkg::OP_FULL:   st_reg <= gde_pkg::ST_FULL;
            gde_pkg::OP_E_RDB:  n_reg  <= cnt_rd;
            gde_pkg::OP_E_WRA:  i_reg  <= cnt_rd;
            gde_pkg::OP_R_START: u_reg <= '0;
            gde_pkg::OP_R_U:    i_reg  <= '0;
            gde_pkg::OP_R_CNT:  n_reg  <= cnt_rd;
            gde_pkg::OP_R_INC:  i_reg  <= i_inc;
            gde_pkg::OP_R_MV:   i_reg  <= i_inc;
            gde_pkg::OP_R_NEXT: u_reg  <= u_reg + 1'b1;
            gde_pkg::OP_S_START:
            begin
                k_reg  <= SPW'(1);
                sp_reg <= SPW'(1);
                e_reg  <= '0;
            end
            gde_pkg::OP_S_LD:
            begin
                u_reg <= stk_v;
                i_reg <= stk_i;
            end
            gde_pkg::OP_S_CNT:  n_reg  <= cnt_rd;
            gde_pkg::OP_S_ADV:  i_reg  <= i_inc;
            gde_pkg::OP_S_POP:  sp_reg <= sp_dec;
            gde_pkg::OP_S_PUSH:
            begin
                k_reg  <= k_reg + 1'b1;
                sp_reg <= sp_reg + 1'b1;
            end
            gde_pkg::OP_EM_LOAD:
            begin
                ovx_reg   <= gde_pkg::VERT_W'(ord_rd);
                olast_reg <= sts.em_last;
                ost_reg   <= gde_pkg::ST_OK;
                ocnt_reg  <= total_reg;
                e_reg     <= e_reg + 1'b1;
            end
            gde_pkg::OP_RES:
            begin
                ovx_reg   <= '0;
                olast_reg <= 1'b1;
                ost_reg   <= st_reg;
                ocnt_reg  <= total_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/gde_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences each operation as datapath commands.
module gde_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gde_pkg::gde_status_t sts,
    output gde_pkg::gde_cmd_t    cmd
);

    gde_pkg::gde_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gde_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = gde_pkg::OP_NOP;
        cmd.in_ready = 1'b0;
        case (state_reg)
            gde_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.op     = gde_pkg::OP_LOAD;
                    state_next = gde_pkg::S_DISPATCH;
                end
            end
            gde_pkg::S_DISPATCH:
            begin
                state_next = gde_pkg::S_RESULT;
                case (sts.func)
                    gde_pkg::FUNC_ADD:
                        cmd.op = sts.a_bad ? gde_pkg::OP_ERR : gde_pkg::OP_ADD;
                    gde_pkg::FUNC_EDGE:
                    begin
                        if (sts.edge_bad)
                        begin
                            cmd.op = gde_pkg::OP_ERR;
                        end
                        else
                        begin
                            cmd.op     = gde_pkg::OP_E_RDA;
                            state_next = gde_pkg::S_E_RDB;
                        end
                    end
                    gde_pkg::FUNC_REMOVE:
                    begin
                        if (sts.a_bad || !sts.a_pres)
                        begin
                            cmd.op = gde_pkg::OP_ERR;
                        end
                        else
                        begin
                            cmd.op     = gde_pkg::OP_R_START;
                            state_next = gde_pkg::S_R_U;
                        end
                    end
                    default:
                    begin
                        if (sts.a_bad)
                        begin
                            cmd.op = gde_pkg::OP_ERR;
                        end
                        else
                        begin
                            cmd.op     = gde_pkg::OP_S_START;
                            state_next = gde_pkg::S_S_TOP;
                        end
                    end
                endcase
            end
            gde_pkg::S_E_RDB:
            begin
                cmd.op     = gde_pkg::OP_E_RDB;
                state_next = gde_pkg::S_E_CHK;
            end
            gde_pkg::S_E_CHK:
            begin
                if (sts.full)
                begin
                    cmd.op     = gde_pkg::OP_FULL;
                    state_next = gde_pkg::S_RESULT;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_E_WRA;
                    state_next = gde_pkg::S_E_WRB;
                end
            end
            gde_pkg::S_E_WRB:
            begin
                cmd.op     = gde_pkg::OP_E_WRB;
                state_next = gde_pkg::S_RESULT;
            end
            gde_pkg::S_R_U:
            begin
                if (sts.u_pres)
                begin
                    cmd.op     = gde_pkg::OP_R_U;
                    state_next = gde_pkg::S_R_CNT;
                end
                else
                begin
                    state_next = gde_pkg::S_R_NEXT;
                end
            end
            gde_pkg::S_R_CNT:
            begin
                cmd.op     = gde_pkg::OP_R_CNT;
                state_next = gde_pkg::S_R_RD;
            end
            gde_pkg::S_R_RD:
            begin
                if (sts.i_ge_n)
                begin
                    state_next = gde_pkg::S_R_NEXT;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_R_RD;
                    state_next = gde_pkg::S_R_CMP;
                end
            end
            gde_pkg::S_R_CMP:
            begin
                if (sts.match)
                begin
                    state_next = gde_pkg::S_R_SH;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_R_INC;
                    state_next = gde_pkg::S_R_RD;
                end
            end
            gde_pkg::S_R_SH:
            begin
                if (sts.sh_end)
                begin
                    cmd.op     = gde_pkg::OP_R_CNTWR;
                    state_next = gde_pkg::S_R_NEXT;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_R_SHRD;
                    state_next = gde_pkg::S_R_MV;
                end
            end
            gde_pkg::S_R_MV:
            begin
                cmd.op     = gde_pkg::OP_R_MV;
                state_next = gde_pkg::S_R_SH;
            end
            gde_pkg::S_R_NEXT:
            begin
                if (sts.u_end)
                begin
                    state_next = gde_pkg::S_RESULT;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_R_NEXT;
                    state_next = gde_pkg::S_R_U;
                end
            end
            gde_pkg::S_S_TOP:
            begin
                cmd.op     = gde_pkg::OP_S_TOP;
                state_next = gde_pkg::S_S_LD;
            end
            gde_pkg::S_S_LD:
            begin
                cmd.op     = gde_pkg::OP_S_LD;
                state_next = gde_pkg::S_S_CNT;
            end
            gde_pkg::S_S_CNT:
            begin
                cmd.op     = gde_pkg::OP_S_CNT;
                state_next = gde_pkg::S_S_NEXT;
            end
            gde_pkg::S_S_NEXT:
            begin
                if (sts.i_ge_n)
                begin
                    cmd.op     = gde_pkg::OP_S_POP;
                    state_next = sts.sp_one ? gde_pkg::S_EM_RD : gde_pkg::S_S_TOP;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_S_ADV;
                    state_next = gde_pkg::S_S_W;
                end
            end
            gde_pkg::S_S_W:
            begin
                if (sts.w_seen)
                begin
                    state_next = gde_pkg::S_S_NEXT;
                end
                else
                begin
                    cmd.op     = gde_pkg::OP_S_PUSH;
                    state_next = gde_pkg::S_S_TOP;
                end
            end
            gde_pkg::S_EM_RD:
            begin
                state_next = gde_pkg::S_EM_OUT;
            end
            gde_pkg::S_EM_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = gde_pkg::OP_EM_LOAD;
                    state_next = sts.em_last ? gde_pkg::S_IDLE : gde_pkg::S_EM_RD;
                end
            end
            gde_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = gde_pkg::OP_RES;
                    state_next = gde_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gde_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/graph_dfs_engine.sv -----
`timescale 1ns / 1ps
// Add vertex and add edge each end in one result word; remove visits every vertex slot,
//   scans the list of each present vertex, then ends in one result word.
// Search: walks the stack over each list entry, then emits one word per visited vertex;
//   the words go out only once the walk ends, since each carries the final vertex count.
// One operation at a time; a result word may wait in the output register.
// Reset: asynchronous, active low; empties the graph (no vertices present, count zero).
module graph_dfs_engine #(
    parameter int MAX_VERTICES = gde_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gde_pkg::MAX_DEGREE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    gde_in_if.sink    in,
    gde_out_if.source out
);

    // controller and datapath talk only through these two groups
    gde_pkg::gde_cmd_t    cmd;
    gde_pkg::gde_status_t sts;

    // sequencer: one state per memory access step of the current operation
    gde_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // stores: neighbour lists, counts, walk stack, visit order; result register
    gde_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in),
        .out   (out),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the DFS engine: graph operations checked word by word against a predictor.
module tb_top;

    localparam int NV        = gde_pkg::MAX_VERTICES_DEF;
    localparam int ND        = gde_pkg::MAX_DEGREE_DEF;
    localparam int N_ITEMS   = 310;
    localparam int MAX_GAP   = 8;
    localparam int SETTLE    = 400;
    localparam int CYC_LIMIT = 5000000;

    typedef struct {
        logic [gde_pkg::FUNC_W-1:0] func;
        logic [gde_pkg::VERT_W-1:0] a;
        logic [gde_pkg::VERT_W-1:0] b;
    } graph_op_t;

    typedef struct {
        logic [gde_pkg::VERT_W-1:0]  vert;
        logic                        last;
        logic [gde_pkg::STAT_W-1:0]  status;
        logic [gde_pkg::TOTAL_W-1:0] count;
    } result_word_t;

    logic clk;
    logic rst_n;

    gde_in_if  op_if ();
    gde_out_if res_if ();

    graph_dfs_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (op_if),
        .out   (res_if)
    );

    // ---------------------------------------------------------------
    // Predicted graph: presence, adjacency lists in order, degrees
    // ---------------------------------------------------------------
    bit                         g_present [NV];
    logic [gde_pkg::VERT_W-1:0] g_adj     [NV][ND];
    int                         g_deg     [NV];
    int                         g_total;

    graph_op_t    pending_ops[$];
    result_word_t expected_words[$];

    int n_accepted;
    int n_words;
    int n_searches;
    int n_errors;
    int cycles;

    function automatic void mark_present(int v);
        if (!g_present[v])
        begin
            g_present[v] = 1'b1;
            g_deg[v]     = 0;
            g_total++;
        end
    endfunction

    function automatic void add_expected(logic [gde_pkg::VERT_W-1:0] v, logic l,
                                         logic [gde_pkg::STAT_W-1:0] st);
        result_word_t w;
        w.vert   = v;
        w.last   = l;
        w.status = st;
        w.count  = gde_pkg::TOTAL_W'(g_total);
        expected_words = {expected_words, w};
    endfunction

    // Preorder walk with an explicit stack; words carry the count at walk end
    function automatic void predict_search(int s);
        bit                vis   [NV];
        int                stk_v [NV];
        int                stk_i [NV];
        int                order [$];
        int                sp;
        int                u;
        int                i;
        int                w;
        for (int k = 0; k < NV; k++)
            vis[k] = 1'b0;
        mark_present(s);
        vis[s] = 1'b1;
        order = {order, s};
        stk_v[0] = s;
        stk_i[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            u = stk_v[sp-1];
            i = stk_i[sp-1];
            if (i >= g_deg[u])
                sp--;
            else
            begin
                stk_i[sp-1] = i + 1;
                w = g_adj[u][i];
                if (!vis[w])
                begin
                    // stale entry to a removed vertex brings it back, list empty
                    mark_present(w);
                    vis[w] = 1'b1;
                    if (order.size() < NV)
                        order = {order, w};
                    if (sp < NV)
                    begin
                        stk_v[sp] = w;
                        stk_i[sp] = 0;
                        sp++;
                    end
                end
            end
        end
        foreach (order[k])
            add_expected(gde_pkg::VERT_W'(order[k]), k == order.size() - 1, gde_pkg::ST_OK);
    endfunction

    function automatic void predict_op(graph_op_t op);
        logic [gde_pkg::STAT_W-1:0] st;
        int                         a;
        int                         b;
        st = gde_pkg::ST_OK;
        a  = op.a;
        b  = op.b;
        case (op.func)
            gde_pkg::FUNC_SEARCH:
            begin
                n_searches++;
                predict_search(a);
                return;
            end
            gde_pkg::FUNC_ADD:
                mark_present(a);
            gde_pkg::FUNC_EDGE:
            begin
                if (a == b || !g_present[a] || !g_present[b])
                    st = gde_pkg::ST_MISSING;
                else if (g_deg[a] >= ND || g_deg[b] >= ND)
                    st = gde_pkg::ST_FULL;
                else
                begin
                    // duplicates are kept
                    g_adj[a][g_deg[a]] = gde_pkg::VERT_W'(b);
                    g_deg[a]++;
                    g_adj[b][g_deg[b]] = gde_pkg::VERT_W'(a);
                    g_deg[b]++;
                end
            end
            default:
            begin
                if (!g_present[a])
                    st = gde_pkg::ST_MISSING;
                else
                begin
                    g_present[a] = 1'b0;
                    g_deg[a]     = 0;
                    g_total--;
                    // only the first occurrence goes; later duplicates stay
                    for (int u = 0; u < NV; u++)
                    begin
                        if (g_present[u])
                        begin
                            for (int i = 0; i < g_deg[u]; i++)
                            begin
                                if (g_adj[u][i] == gde_pkg::VERT_W'(a))
                                begin
                                    for (int j = i; j < g_deg[u] - 1; j++)
                                        g_adj[u][j] = g_adj[u][j+1];
                                    g_deg[u]--;
                                    break;
                                end
                            end
                        end
                    end
                end
            end
        endcase
        add_expected('0, 1'b1, st);
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding", cycles,
                     expected_words.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver: one op word at a time, random gap drawn per word
    // ---------------------------------------------------------------
    int  op_gap;
    bit  op_burst;

    always @(posedge clk or negedge rst_n)
    begin
        graph_op_t nxt;
        bit        fire;
        if (!rst_n)
        begin
            op_if.valid    <= 1'b0;
            op_if.func     <= gde_pkg::FUNC_ADD;
            op_if.vertex_a <= '0;
            op_if.vertex_b <= '0;
            op_gap   = 0;
            op_burst = 1'b0;
        end
        else
        begin
            fire = op_if.valid && op_if.ready;
            if (fire)
            begin
                nxt.func = op_if.func;
                nxt.a    = op_if.vertex_a;
                nxt.b    = op_if.vertex_b;
                predict_op(nxt);
                n_accepted++;
                if ($urandom_range(0, 15) == 0)
                    op_burst = !op_burst;
                op_gap = op_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!op_if.valid || fire)
            begin
                if (op_gap > 0)
                begin
                    op_if.valid <= 1'b0;
                    op_gap--;
                end
                else if (pending_ops.size() > 0)
                begin
                    nxt = pending_ops.pop_front();
                    op_if.func     <= nxt.func;
                    op_if.vertex_a <= nxt.a;
                    op_if.vertex_b <= nxt.b;
                    op_if.valid    <= 1'b1;
                end
                else
                    op_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, checks each result word in order
    // ---------------------------------------------------------------
    int res_stall;
    bit res_burst;

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t e;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            res_stall = 0;
            res_burst = 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                n_words++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: vertex %0d last %0d status %0d",
                           res_if.visited_vertex, res_if.last, res_if.status);
                    n_errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (res_if.visited_vertex !== e.vert)
                    begin
                        $error("visited_vertex: expected %0d, got %0d", e.vert,
                               res_if.visited_vertex);
                        n_errors++;
                    end
                    if (res_if.last !== e.last)
                    begin
                        $error("last: expected %0d, got %0d", e.last, res_if.last);
                        n_errors++;
                    end
                    if (res_if.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, res_if.status);
                        n_errors++;
                    end
                    if (res_if.vertex_count !== e.count)
                    begin
                        $error("vertex_count: expected %0d, got %0d", e.count,
                               res_if.vertex_count);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    res_burst = !res_burst;
                res_stall = res_burst ? 0 : $urandom_range(0, MAX_GAP);
                res_if.ready <= (res_stall == 0);
            end
            else if (res_stall > 0)
            begin
                res_stall--;
                res_if.ready <= (res_stall == 0);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic void queue_op(logic [gde_pkg::FUNC_W-1:0] f, int a, int b);
        graph_op_t op;
        op.func = f;
        op.a    = gde_pkg::VERT_W'(a);
        op.b    = gde_pkg::VERT_W'(b);
        pending_ops = {pending_ops, op};
    endfunction

    function automatic int win(int base);
        return base + $urandom_range(0, 7);
    endfunction

    initial
    begin
        int kind;
        int base;
        int x;
        int y;
        int n_full;
        n_accepted = 0;
        n_words    = 0;
        n_searches = 0;
        n_errors   = 0;
        cycles     = 0;
        g_total    = 0;
        for (int v = 0; v < NV; v++)
        begin
            g_present[v] = 1'b0;
            g_deg[v]     = 0;
        end
        rst_n = 1'b0;

        // directed: field extremes, every op, the listed corner cases
        queue_op(gde_pkg::FUNC_ADD, 0, 63);
        queue_op(gde_pkg::FUNC_ADD, 63, 0);
        queue_op(gde_pkg::FUNC_ADD, 0, 0);          // already there
        queue_op(gde_pkg::FUNC_EDGE, 0, 63);
        queue_op(gde_pkg::FUNC_EDGE, 63, 63);       // self edge
        queue_op(gde_pkg::FUNC_EDGE, 0, 5);         // absent end
        queue_op(gde_pkg::FUNC_EDGE, 0, 63);        // duplicate edge
        queue_op(gde_pkg::FUNC_SEARCH, 0, 0);
        queue_op(gde_pkg::FUNC_SEARCH, 42, 63);     // absent start
        queue_op(gde_pkg::FUNC_REMOVE, 17, 0);      // absent
        queue_op(gde_pkg::FUNC_ADD, 21, 0);
        queue_op(gde_pkg::FUNC_EDGE, 21, 63);
        queue_op(gde_pkg::FUNC_EDGE, 21, 0);
        queue_op(gde_pkg::FUNC_REMOVE, 63, 0);      // leaves a duplicate in 0's list
        queue_op(gde_pkg::FUNC_SEARCH, 0, 0);       // walks the stale entry
        queue_op(gde_pkg::FUNC_REMOVE, 0, 0);
        queue_op(gde_pkg::FUNC_SEARCH, 21, 0);
        queue_op(gde_pkg::FUNC_REMOVE, 42, 0);
        queue_op(gde_pkg::FUNC_SEARCH, 63, 63);

        // random: mostly small connected clusters, some noise, full-list bursts
        n_full = 0;
        while (pending_ops.size() < N_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            base = $urandom_range(0, NV - 8);
            if (kind <= 5)
            begin
                repeat ($urandom_range(3, 6))
                    queue_op(gde_pkg::FUNC_ADD, win(base), 0);
                repeat ($urandom_range(3, 8))
                    queue_op(gde_pkg::FUNC_EDGE, win(base), win(base));
                if ($urandom_range(0, 2) == 0)
                    queue_op(gde_pkg::FUNC_EDGE, win(base), $urandom_range(0, NV - 1));
                queue_op(gde_pkg::FUNC_SEARCH, win(base), 0);
                if ($urandom_range(0, 1) == 0)
                    queue_op(gde_pkg::FUNC_REMOVE, win(base), 0);
            end
            else if (kind <= 7)
            begin
                repeat (5)
                    queue_op(gde_pkg::FUNC_W'($urandom_range(0, 3)),
                             $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
            end
            else if (kind == 8 && n_full < 2 && pending_ops.size() + ND + 8 <= N_ITEMS)
            begin
                // fill one list past its capacity, then walk and tear down
                n_full++;
                x = win(base);
                y = (x == NV - 1) ? x - 1 : x + 1;
                queue_op(gde_pkg::FUNC_ADD, x, 0);
                queue_op(gde_pkg::FUNC_ADD, y, 0);
                repeat (ND + 2)
                    queue_op(gde_pkg::FUNC_EDGE, x, y);
                queue_op(gde_pkg::FUNC_SEARCH, x, 0);
                queue_op(gde_pkg::FUNC_REMOVE, y, 0);
                queue_op(gde_pkg::FUNC_SEARCH, x, 0);
                queue_op(gde_pkg::FUNC_REMOVE, x, 0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    queue_op(gde_pkg::FUNC_REMOVE, win(base), 0);
                queue_op(gde_pkg::FUNC_SEARCH, win(base), 0);
            end
        end
        x = pending_ops.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_accepted == x && expected_words.size() == 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d operations (%0d searches), %0d result words checked",
                 n_accepted, n_searches, n_words);
        $display("Covered extremes, duplicates, stale entries and full lists, %0d errors",
                 n_errors);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
